// ===== hw/rtl/csfd_pkg.sv =====
// Shared constants and pipeline types for the CAN signal field decoder.
package csfd_pkg;

  localparam int FRAME_BYTES_DEF = 8;

  // signal type codes
  localparam logic [3:0] SIG_U8    = 4'd0;
  localparam logic [3:0] SIG_S8    = 4'd1;
  localparam logic [3:0] SIG_U16LE = 4'd2;
  localparam logic [3:0] SIG_U16BE = 4'd3;
  localparam logic [3:0] SIG_S16LE = 4'd4;
  localparam logic [3:0] SIG_S16BE = 4'd5;
  localparam logic [3:0] SIG_U32LE = 4'd6;
  localparam logic [3:0] SIG_U32BE = 4'd7;
  localparam logic [3:0] SIG_S32LE = 4'd8;
  localparam logic [3:0] SIG_S32BE = 4'd9;
  localparam logic [3:0] SIG_F32LE = 4'd10;
  localparam logic [3:0] SIG_F32BE = 4'd11;

  // configuration register indexes
  localparam logic [2:0] REG_SIGNAL_TYPE   = 3'd0;
  localparam logic [2:0] REG_START_BYTE    = 3'd1;
  localparam logic [2:0] REG_GAIN          = 3'd2;
  localparam logic [2:0] REG_BIAS          = 3'd3;
  localparam logic [2:0] REG_LOWER_LIMIT   = 3'd4;
  localparam logic [2:0] REG_UPPER_LIMIT   = 3'd5;
  localparam logic [2:0] REG_LIMIT_ENABLES = 3'd6;

  // status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FAULT = 2'd1;
  localparam logic [1:0] ST_BELOW = 2'd2;
  localparam logic [1:0] ST_ABOVE = 2'd3;

  // decoded field, ready for the multiplier
  typedef struct packed {
    logic        bad;
    logic        flt;
    logic        neg;
    logic [7:0]  expo;
    logic [31:0] raw;
    logic [31:0] opnd;
  } csfd_field_t;

  typedef struct packed {
    logic        bad;
    logic        flt;
    logic        neg;
    logic [7:0]  expo;
    logic [31:0] raw;
    logic [63:0] prod;
  } csfd_prod_t;

  typedef struct packed {
    logic        bad;
    logic        neg;
    logic        huge;
    logic [31:0] raw;
    logic [63:0] mag;
  } csfd_mag_t;

  typedef struct packed {
    logic        bad;
    logic [31:0] raw;
    logic [63:0] value;
  } csfd_res_t;

endpackage

// ===== hw/rtl/csfd_extract.sv =====
// Signal type decode, byte gather and operand forming for one payload.
module csfd_extract
  import csfd_pkg::*;
#(
  parameter int FRAME_BYTES = FRAME_BYTES_DEF
) (
  input  logic [63:0]  payload,
  input  logic [3:0]   signal_type,
  input  logic [2:0]   start_byte,
  input  logic         gain_neg,
  output csfd_field_t  field
);

  logic [3:0]  size;
  logic        big;
  logic        sgn;
  logic        flt;
  logic        type_ok;
  logic        overrun;
  logic [7:0]  byte_sel [4];
  logic [31:0] raw_le;
  logic [31:0] raw_be;
  logic [31:0] raw;
  logic signed [32:0] sval;
  logic signed [32:0] sval_neg;
  logic        rneg;
  logic [31:0] rmag;
  logic [7:0]  expo;
  logic [23:0] mant;

  always_comb begin
    size    = 4'd1;
    big     = 1'b0;
    sgn     = 1'b0;
    flt     = 1'b0;
    type_ok = 1'b1;
    unique case (signal_type)
      SIG_U8:    size = 4'd1;
      SIG_S8:    begin size = 4'd1; sgn = 1'b1; end
      SIG_U16LE: size = 4'd2;
      SIG_U16BE: begin size = 4'd2; big = 1'b1; end
      SIG_S16LE: begin size = 4'd2; sgn = 1'b1; end
      SIG_S16BE: begin size = 4'd2; sgn = 1'b1; big = 1'b1; end
      SIG_U32LE: size = 4'd4;
      SIG_U32BE: begin size = 4'd4; big = 1'b1; end
      SIG_S32LE: begin size = 4'd4; sgn = 1'b1; end
      SIG_S32BE: begin size = 4'd4; sgn = 1'b1; big = 1'b1; end
      SIG_F32LE: begin size = 4'd4; flt = 1'b1; end
      SIG_F32BE: begin size = 4'd4; flt = 1'b1; big = 1'b1; end
      default:   type_ok = 1'b0;
    endcase
  end

  assign overrun = ({1'b0, start_byte} + size) > 4'(FRAME_BYTES);

  // byte positions wrap within the eight-byte word
  always_comb begin
    for (int k = 0; k < 4; k++) begin
      byte_sel[k] = payload[8*(3'(start_byte + 3'(k))) +: 8];
    end
  end

  always_comb begin
    unique case (size)
      4'd1:    begin
        raw_le = {24'd0, byte_sel[0]};
        raw_be = {24'd0, byte_sel[0]};
      end
      4'd2:    begin
        raw_le = {16'd0, byte_sel[1], byte_sel[0]};
        raw_be = {16'd0, byte_sel[0], byte_sel[1]};
      end
      default: begin
        raw_le = {byte_sel[3], byte_sel[2], byte_sel[1], byte_sel[0]};
        raw_be = {byte_sel[0], byte_sel[1], byte_sel[2], byte_sel[3]};
      end
    endcase
  end

  assign raw = big ? raw_be : raw_le;

  always_comb begin
    if (!sgn) begin
      sval = $signed({1'b0, raw});
    end else begin
      unique case (size)
        4'd1:    sval = $signed({{25{raw[7]}}, raw[7:0]});
        4'd2:    sval = $signed({{17{raw[15]}}, raw[15:0]});
        default: sval = $signed({raw[31], raw});
      endcase
    end
  end

  assign sval_neg = -sval;
  assign rneg     = sval[32];
  assign rmag     = rneg ? sval_neg[31:0] : sval[31:0];

  assign expo = raw[30:23];
  assign mant = (expo == 8'd0) ? {1'b0, raw[22:0]} : {1'b1, raw[22:0]};

  always_comb begin
    field.bad  = !type_ok || overrun || (flt && (&expo));
    field.flt  = flt;
    field.neg  = flt ? (raw[31] ^ gain_neg) : (rneg ^ gain_neg);
    // subnormals use the same scale as exponent one
    field.expo = (expo == 8'd0) ? 8'd1 : expo;
    field.raw  = (!type_ok || overrun) ? 32'd0 : raw;
    field.opnd = flt ? {8'd0, mant} : rmag;
  end

endmodule

// ===== hw/rtl/csfd_bias_sat.sv =====
// Adds the Q47.16 bias to a sign-magnitude product and saturates to 64 bits.
module csfd_bias_sat
  import csfd_pkg::*;
(
  input  logic               neg,
  input  logic               huge,
  input  logic [63:0]        mag,
  input  logic [63:0]        bias,
  output logic signed [63:0] result
);

  localparam logic [63:0] SAT_MAX = {1'b0, {63{1'b1}}};
  localparam logic [63:0] SAT_MIN = {1'b1, 63'd0};

  logic signed [65:0] pval;
  logic signed [65:0] sum;
  logic               ovf;

  assign pval = neg ? -$signed({2'b00, mag}) : $signed({2'b00, mag});
  assign sum  = pval + $signed({{2{bias[63]}}, bias});
  assign ovf  = (sum[65:63] != 3'b000) && (sum[65:63] != 3'b111);

  always_comb begin
    if (huge) begin
      result = neg ? $signed(SAT_MIN) : $signed(SAT_MAX);
    end else if (ovf) begin
      result = sum[65] ? $signed(SAT_MIN) : $signed(SAT_MAX);
    end else begin
      result = sum[63:0];
    end
  end

endmodule

// ===== hw/rtl/can_signal_field_decoder_unit.sv =====
// Top level: config registers and five-stage decode, scale and limit pipeline.
//
//   channel | direction | handshake          | words
//   --------+-----------+--------------------+-------------------------------------
//   in      | to block  | in_valid/in_stall  | payload
//   out     | from block| out_valid/out_stall| scaled_value, raw_bits, status
//   cfg     | to block  | cfg_valid/cfg_ready| cfg_index, cfg_data
//
// One word per cycle while out_stall is low; each word passes through the registers
// input, 32x32 product, float shift, bias add and limit check, in that order.
// The stages move on a per-stage enable, so empty stages fill while out_stall
// is high; in_stall rises only when every stage holds a word.
// rst is synchronous: it empties the pipeline and loads the register defaults.
module can_signal_field_decoder_unit
  import csfd_pkg::*;
#(
  parameter int FRAME_BYTES = FRAME_BYTES_DEF
) (
  input  logic               clk,
  input  logic               rst,

  input  logic               in_valid,
  output logic               in_stall,
  input  logic [63:0]        payload,

  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [63:0] scaled_value,
  output logic [31:0]        raw_bits,
  output logic [1:0]         status,

  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [63:0]        cfg_data
);

  localparam logic [7:0] F32_UNIT_EXP = 8'd150;  // exponent where ulp is 2^0

  logic [3:0]  signal_type;
  logic [2:0]  start_byte;
  logic [31:0] gain;
  logic [63:0] bias;
  logic [63:0] lower_limit;
  logic [63:0] upper_limit;
  logic [1:0]  limit_enables;

  logic        s0_valid, s1_valid, s2_valid, s3_valid;
  logic        s0_en, s1_en, s2_en, s3_en, out_en;
  logic [63:0] s0_word;
  csfd_prod_t  s1;
  csfd_mag_t   s2;
  csfd_res_t   s3;

  csfd_field_t field;
  logic        gain_neg;
  logic [31:0] gain_mag;
  logic [63:0] prod_next;
  csfd_mag_t   s2_next;
  logic [7:0]  sh_up;
  logic [7:0]  sh_dn;
  logic [127:0] wide;
  logic [64:0] rnd;
  logic signed [63:0] sat_value;
  logic [1:0]  status_next;

  // config
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      signal_type   <= SIG_U8;
      start_byte    <= 3'd0;
      gain          <= 32'h0001_0000;
      bias          <= 64'd0;
      lower_limit   <= 64'd0;
      upper_limit   <= 64'd0;
      limit_enables <= 2'd0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_SIGNAL_TYPE:   signal_type   <= cfg_data[3:0];
        REG_START_BYTE:    start_byte    <= cfg_data[2:0];
        REG_GAIN:          gain          <= cfg_data[31:0];
        REG_BIAS:          bias          <= cfg_data;
        REG_LOWER_LIMIT:   lower_limit   <= cfg_data;
        REG_UPPER_LIMIT:   upper_limit   <= cfg_data;
        REG_LIMIT_ENABLES: limit_enables <= cfg_data[1:0];
        default: ;
      endcase
    end
  end

  // pipeline flow control
  assign out_en   = !out_valid || !out_stall;
  assign s3_en    = !s3_valid || out_en;
  assign s2_en    = !s2_valid || s3_en;
  assign s1_en    = !s1_valid || s2_en;
  assign s0_en    = !s0_valid || s1_en;
  assign in_stall = !s0_en;

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid  <= 1'b0;
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      s3_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (s0_en)  s0_valid  <= in_valid;
      if (s1_en)  s1_valid  <= s0_valid;
      if (s2_en)  s2_valid  <= s1_valid;
      if (s3_en)  s3_valid  <= s2_valid;
      if (out_en) out_valid <= s3_valid;
    end
  end

  // stage 1: field decode and multiply
  assign gain_neg = gain[31];
  assign gain_mag = gain_neg ? (32'd0 - gain) : gain;

  csfd_extract #(
    .FRAME_BYTES (FRAME_BYTES)
  ) u_extract (
    .payload     (s0_word),
    .signal_type (signal_type),
    .start_byte  (start_byte),
    .gain_neg    (gain_neg),
    .field       (field)
  );

  assign prod_next = {32'd0, field.opnd} * {32'd0, gain_mag};

  // stage 2: float exponent shift with round half away from zero
  always_comb begin
    sh_up        = 8'd0;
    sh_dn        = 8'd0;
    wide         = 128'd0;
    rnd          = 65'd0;
    s2_next.bad  = s1.bad;
    s2_next.neg  = s1.neg;
    s2_next.raw  = s1.raw;
    s2_next.huge = 1'b0;
    s2_next.mag  = s1.prod;
    if (s1.flt) begin
      if (s1.expo > F32_UNIT_EXP) begin
        sh_up = s1.expo - F32_UNIT_EXP;
        if (sh_up >= 8'd64) begin
          s2_next.huge = (s1.prod != 64'd0);
          s2_next.mag  = 64'd0;
        end else begin
          wide         = {64'd0, s1.prod} << sh_up[5:0];
          s2_next.huge = |wide[127:64];
          s2_next.mag  = wide[63:0];
        end
      end else if (s1.expo < F32_UNIT_EXP) begin
        sh_dn = F32_UNIT_EXP - s1.expo;
        if (sh_dn > 8'd63) begin
          s2_next.mag = 64'd0;
        end else begin
          rnd = ({1'b0, s1.prod} + (65'd1 << 6'(sh_dn[5:0] - 6'd1))) >> sh_dn[5:0];
          s2_next.mag = rnd[63:0];
        end
      end
    end
  end

  // stage 3: bias and saturation
  csfd_bias_sat u_bias_sat (
    .neg    (s2.neg),
    .huge   (s2.huge),
    .mag    (s2.mag),
    .bias   (bias),
    .result (sat_value)
  );

  // stage 4: limit check, lower first
  always_comb begin
    priority if (s3.bad) begin
      status_next = ST_FAULT;
    end else if (limit_enables[0] && ($signed(s3.value) < $signed(lower_limit))) begin
      status_next = ST_BELOW;
    end else if (limit_enables[1] && ($signed(upper_limit) < $signed(s3.value))) begin
      status_next = ST_ABOVE;
    end else begin
      status_next = ST_OK;
    end
  end

  // data registers
  always_ff @(posedge clk) begin
    if (s0_en) s0_word <= payload;
    if (s1_en) begin
      s1.bad  <= field.bad;
      s1.flt  <= field.flt;
      s1.neg  <= field.neg;
      s1.expo <= field.expo;
      s1.raw  <= field.raw;
      s1.prod <= prod_next;
    end
    if (s2_en) s2 <= s2_next;
    if (s3_en) begin
      s3.bad   <= s2.bad;
      s3.raw   <= s2.raw;
      s3.value <= s2.bad ? 64'd0 : sat_value;
    end
    if (out_en) begin
      scaled_value <= s3.value;
      raw_bits     <= s3.raw;
      status       <= status_next;
    end
  end

endmodule
